### rtl/core/rgbhsv_pkg.sv
// Shared types, constants and the restoring-division step for the RGB to HSV pipeline.
// Used by rgb_to_hsv_integer; depends on nothing else.
package rgbhsv_pkg;

  // Number of register stages from input capture to output register
  localparam int unsigned NUM_STAGES = 9;
  // Division stages, two quotient bits each
  localparam int unsigned DIV_STAGES = 4;

  // Hue sector offsets (twice the sector index times 256)
  localparam logic [10:0] OFS_GREEN = 11'd512;
  localparam logic [10:0] OFS_BLUE  = 11'd1024;

  // Division by 6 as multiply by 683 and shift by 12; exact for values up to 1279
  localparam logic [9:0] RECIP6      = 10'd683;
  localparam int unsigned RECIP_SHIFT = 12;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // After max/min search
  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] d;
    sector_t    sector;
    logic       dneg;
    logic [7:0] dmag;
  } front_t;

  // Both dividers side by side: rem1/q1 for saturation, rem2/q2 for hue
  typedef struct packed {
    logic [15:0] rem1;
    logic [15:0] rem2;
    logic [7:0]  q1;
    logic [7:0]  q2;
    logic [7:0]  hi;
    logic [7:0]  d;
    sector_t     sector;
    logic        dneg;
    logic        grey;
  } div_t;

  // Signed hue before the divide by 6, as sign and magnitude
  typedef struct packed {
    logic [10:0] hmag;
    logic        hneg;
    logic        grey;
    logic [7:0]  sat;
    logic [7:0]  hi;
  } hue_t;

  // Reciprocal product
  typedef struct packed {
    logic [19:0] prod;
    logic        hneg;
    logic        grey;
    logic [7:0]  sat;
    logic [7:0]  hi;
  } prod_t;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic [7:0] dvs,
                                           input logic [2:0] sh);
    logic [15:0] trial;
    trial = {8'd0, dvs} << sh;
    if (rem >= trial) begin
      return {1'b1, rem - trial};
    end
    return {1'b0, rem};
  endfunction

endpackage

### rtl/core/rgb_to_hsv_integer.sv
// RGB to HSV conversion of 8-bit pixels, fully pipelined, integer arithmetic.
// Depends on rgbhsv_pkg (types, constants, division step).
//
//  channel | ports            | tdata fields, low bit up
//  --------+------------------+-----------------------------------------------
//  input   | in_tvalid/tready | red[7:0] green[15:8] blue[23:16]
//  result  | out_tvalid/tready| hue[7:0] saturation[15:8] brightness[23:16]
//
// One item per cycle sustained while out_tready stays high; nine register stages lie
// between the edge that accepts an item and out_tvalid.
// The two dividers (saturation and hue) run as 4 stages of 2 quotient bits each;
// the divide by 6 is a reciprocal multiply with its own register stage.
// rst_n (synchronous) clears the stage valid bits only.
// Each stage advances when the stage after it can take its item, so bubbles
// close up and a stall on out_tready holds each item that has no empty stage ahead of it.
module rgb_to_hsv_integer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // hue[7:0], saturation[15:8], brightness[23:16]
);

  localparam int unsigned NST = rgbhsv_pkg::NUM_STAGES;
  localparam int unsigned NDV = rgbhsv_pkg::DIV_STAGES;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  rgbhsv_pkg::front_t front_r, front_nxt;
  rgbhsv_pkg::div_t   ds_r [NDV+1];
  rgbhsv_pkg::div_t   ds0_nxt;
  rgbhsv_pkg::hue_t   hue_r, hue_nxt;
  rgbhsv_pkg::prod_t  prod_r, prod_nxt;
  logic [7:0]         out_hue_r, out_sat_r, out_bri_r;
  logic [7:0]         out_hue_nxt;

  // Ready chain: a stage can load when empty or when its successor loads
  always_comb begin
    rdy[NST-1] = out_tready || !vld_r[NST-1];
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = rdy[i+1] || !vld_r[i];
    end
  end

  assign in_tready = rdy[0];

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Stage 0: max, min, sector and signed channel difference
  always_comb begin
    logic [7:0]        r, g, b, hi, lo;
    logic signed [8:0] diff;
    r = in_tdata[7:0];
    g = in_tdata[15:8];
    b = in_tdata[23:16];
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    priority if (r == hi) begin
      front_nxt.sector = rgbhsv_pkg::SEC_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == hi) begin
      front_nxt.sector = rgbhsv_pkg::SEC_GREEN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      front_nxt.sector = rgbhsv_pkg::SEC_BLUE;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    front_nxt.hi   = hi;
    front_nxt.d    = hi - lo;
    front_nxt.dneg = diff[8];
    front_nxt.dmag = diff[8] ? 8'(~diff + 9'sd1) : diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      front_r <= front_nxt;
    end
  end

  // Stage 1: numerators 255*d and 255*|diff|
  always_comb begin
    ds0_nxt.rem1   = {front_r.d, 8'd0} - {8'd0, front_r.d};
    ds0_nxt.rem2   = {front_r.dmag, 8'd0} - {8'd0, front_r.dmag};
    ds0_nxt.q1     = '0;
    ds0_nxt.q2     = '0;
    ds0_nxt.hi     = front_r.hi;
    ds0_nxt.d      = front_r.d;
    ds0_nxt.sector = front_r.sector;
    ds0_nxt.dneg   = front_r.dneg;
    ds0_nxt.grey   = (front_r.d == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ds_r[0] <= ds0_nxt;
    end
  end

  // Stages 2..5: restoring division, two quotient bits per stage, MSB first
  for (genvar k = 0; k < NDV; k++) begin : g_div
    localparam logic [2:0] SH_HI = 3'(2 * (NDV - k) - 1);
    localparam logic [2:0] SH_LO = 3'(2 * (NDV - k) - 2);
    rgbhsv_pkg::div_t ds_nxt;
    logic [16:0]      a1, b1, a2, b2;

    always_comb begin
      a1 = rgbhsv_pkg::div_step(ds_r[k].rem1, ds_r[k].hi, SH_HI);
      b1 = rgbhsv_pkg::div_step(a1[15:0], ds_r[k].hi, SH_LO);
      a2 = rgbhsv_pkg::div_step(ds_r[k].rem2, ds_r[k].d, SH_HI);
      b2 = rgbhsv_pkg::div_step(a2[15:0], ds_r[k].d, SH_LO);
      ds_nxt      = ds_r[k];
      ds_nxt.rem1 = b1[15:0];
      ds_nxt.rem2 = b2[15:0];
      ds_nxt.q1   = {ds_r[k].q1[5:0], a1[16], b1[16]};
      ds_nxt.q2   = {ds_r[k].q2[5:0], a2[16], b2[16]};
    end

    always_ff @(posedge clk) begin
      if (rdy[k+2]) begin
        ds_r[k+1] <= ds_nxt;
      end
    end
  end

  // Stage 6: add sector offset, saturation masked for grey
  always_comb begin
    logic [10:0] q2x;
    q2x = {3'd0, ds_r[NDV].q2};
    hue_nxt.hneg = 1'b0;
    unique case (ds_r[NDV].sector)
      rgbhsv_pkg::SEC_RED: begin
        hue_nxt.hmag = q2x;
        hue_nxt.hneg = ds_r[NDV].dneg;
      end
      rgbhsv_pkg::SEC_GREEN: begin
        hue_nxt.hmag = ds_r[NDV].dneg ? rgbhsv_pkg::OFS_GREEN - q2x
                                      : rgbhsv_pkg::OFS_GREEN + q2x;
      end
      rgbhsv_pkg::SEC_BLUE: begin
        hue_nxt.hmag = ds_r[NDV].dneg ? rgbhsv_pkg::OFS_BLUE - q2x
                                      : rgbhsv_pkg::OFS_BLUE + q2x;
      end
      default: begin
        hue_nxt.hmag = q2x;
      end
    endcase
    hue_nxt.grey = ds_r[NDV].grey;
    hue_nxt.sat  = ds_r[NDV].grey ? 8'd0 : ds_r[NDV].q1;
    hue_nxt.hi   = ds_r[NDV].hi;
  end

  always_ff @(posedge clk) begin
    if (rdy[NDV+2]) begin
      hue_r <= hue_nxt;
    end
  end

  // Stage 7: magnitude times reciprocal of 6
  always_comb begin
    logic [20:0] full;
    full = {10'd0, hue_r.hmag} * {11'd0, rgbhsv_pkg::RECIP6};
    prod_nxt.prod = full[19:0];
    prod_nxt.hneg = hue_r.hneg;
    prod_nxt.grey = hue_r.grey;
    prod_nxt.sat  = hue_r.sat;
    prod_nxt.hi   = hue_r.hi;
  end

  always_ff @(posedge clk) begin
    if (rdy[NDV+3]) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 8: quotient by 6, negative hue wraps by 256
  always_comb begin
    logic [7:0] qm;
    qm = prod_r.prod[rgbhsv_pkg::RECIP_SHIFT +: 8];
    if (prod_r.grey) begin
      out_hue_nxt = 8'd0;
    end else if (prod_r.hneg) begin
      out_hue_nxt = ~qm + 8'd1;
    end else begin
      out_hue_nxt = qm;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_hue_r <= out_hue_nxt;
      out_sat_r <= prod_r.sat;
      out_bri_r <= prod_r.hi;
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {out_bri_r, out_sat_r, out_hue_r};

  // Grey or black pixels carry hue 0
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:8] == 8'd0 |-> out_tdata[7:0] == 8'd0)
    else $error("nonzero hue with zero saturation");

  // Black pixel has zero saturation
  a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:16] == 8'd0 |-> out_tdata[15:8] == 8'd0)
    else $error("nonzero saturation for black pixel");

  // Input only stalls when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> &vld_r)
    else $error("input stalled with a bubble in the pipeline");

  // Final remainders lie below their divisors where the divisor is nonzero
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NDV+1] |-> (ds_r[NDV].rem1 < {8'd0, ds_r[NDV].hi} || ds_r[NDV].hi == 8'd0) &&
                     (ds_r[NDV].rem2 < {8'd0, ds_r[NDV].d} || ds_r[NDV].d == 8'd0))
    else $error("division remainder out of range");

endmodule
